### hw/rtl/prt_pkg.sv
// Shared types and codes of the peer registry table.
package prt_pkg;

    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_UNREGISTER = 2'd1,
        OP_LIST       = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        KIND_ASSIGNED   = 3'd0,
        KIND_REMOVED    = 3'd1,
        KIND_NOT_FOUND  = 3'd2,
        KIND_LIST_START = 3'd3,
        KIND_LIST_ENTRY = 3'd4,
        KIND_LIST_END   = 3'd5
    } kind_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] client_address;
        logic [15:0] client_port;
        logic [31:0] sequence_key;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] entry_address;
        logic [15:0] entry_port;
        logic [31:0] entry_sequence;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] address;
        logic [15:0] port;
        logic [31:0] seq_num;
    } slot_t;

endpackage

### hw/rtl/prt_slot_mem.sv
// Slot storage of the peer registry table: one write port, one registered read port.
module prt_slot_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  prt_pkg::slot_t  wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output prt_pkg::slot_t  rd_data
);

    prt_pkg::slot_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/peer_registry_table.sv
// Top level of the peer registry table: request sequencer, slot scan and result register.
//
// The table holds TABLE_DEPTH peer slots and handles one request item at a time;
// req_stall is high from acceptance until the last result of that item has been
// loaded into the result register, or until a register request on a full table
// is dropped. A single slot index walks the table one slot per cycle, though a
// list scan holds while rsp_stall keeps an entry waiting, and the slot contents
// sit in a memory with one read port, so the scan sets the latency: a register
// request ends at the lowest free slot (a full table gives no result), an
// unregister scans up to the whole table, and a list emits one entry per cycle
// over occupied slots while rsp_stall is low. A finished result waits in the
// output register while the next request is accepted.
module peer_registry_table #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  prt_pkg::in_item_t   req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output prt_pkg::out_item_t  rsp
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IW = $clog2(TABLE_DEPTH + 1);
    localparam logic [IW-1:0] DEPTH_CNT = IW'(TABLE_DEPTH);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_REG    = 6'b000010,
        ST_UNR    = 6'b000100,
        ST_LSTART = 6'b001000,
        ST_LIST   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic                   p_valid_reg, p_valid_next;
    logic [AW-1:0]          p_idx_reg, p_idx_next;
    logic [TABLE_DEPTH-1:0] slot_valid_reg, slot_valid_next;
    logic [31:0]            next_number_reg, next_number_next;
    logic                   out_valid_reg, out_valid_next;

    // Request payload and pending result; no reset needed.
    logic [31:0]            addr_reg;
    logic [15:0]            port_reg;
    logic [31:0]            key_reg;
    prt_pkg::kind_t         res_kind_reg, res_kind_next;
    logic [31:0]            res_seq_reg, res_seq_next;
    prt_pkg::out_item_t     out_item_reg, out_item_next;

    logic                   accept;
    logic                   out_free;
    logic                   idx_done;
    logic [AW-1:0]          idx_addr;
    logic                   mem_wr_en;
    prt_pkg::slot_t         mem_wr_data;
    logic                   mem_rd_en;
    prt_pkg::slot_t         mem_rd_data;
    logic                   consume;
    logic                   can_issue;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign idx_done  = (idx_reg == DEPTH_CNT);
    assign idx_addr  = idx_reg[AW-1:0];
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    assign mem_wr_data = '{address: addr_reg, port: port_reg, seq_num: next_number_reg};

    prt_slot_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (idx_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (idx_addr),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        p_valid_next     = 1'b0;
        p_idx_next       = p_idx_reg;
        slot_valid_next  = slot_valid_reg;
        next_number_next = next_number_reg;
        res_kind_next    = res_kind_reg;
        res_seq_next     = res_seq_reg;
        out_valid_next   = out_valid_reg && rsp_stall;
        out_item_next    = out_item_reg;
        mem_wr_en        = 1'b0;
        mem_rd_en        = 1'b0;
        consume          = 1'b0;
        can_issue        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    case (req.operation)
                        prt_pkg::OP_REGISTER:   state_next = ST_REG;
                        prt_pkg::OP_UNREGISTER: state_next = ST_UNR;
                        prt_pkg::OP_LIST:       state_next = ST_LSTART;
                        default:                state_next = ST_IDLE;
                    endcase
                end
            end

            ST_REG:
            begin
                if (idx_done)
                begin
                    // Table full: the request is dropped without a result.
                    state_next = ST_IDLE;
                end
                else if (!slot_valid_reg[idx_addr])
                begin
                    mem_wr_en                 = 1'b1;
                    slot_valid_next[idx_addr] = 1'b1;
                    res_kind_next             = prt_pkg::KIND_ASSIGNED;
                    res_seq_next              = next_number_reg;
                    next_number_next          = next_number_reg + 32'd1;
                    state_next                = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end

            ST_UNR:
            begin
                // Reads are issued one slot ahead of the key compare.
                if (p_valid_reg && slot_valid_reg[p_idx_reg]
                    && (mem_rd_data.seq_num == key_reg))
                begin
                    slot_valid_next[p_idx_reg] = 1'b0;
                    res_kind_next              = prt_pkg::KIND_REMOVED;
                    res_seq_next               = '0;
                    state_next                 = ST_DONE;
                end
                else if (!p_valid_reg && idx_done)
                begin
                    res_kind_next = prt_pkg::KIND_NOT_FOUND;
                    res_seq_next  = '0;
                    state_next    = ST_DONE;
                end
                else if (!idx_done)
                begin
                    mem_rd_en    = 1'b1;
                    p_valid_next = 1'b1;
                    p_idx_next   = idx_addr;
                    idx_next     = idx_reg + IW'(1);
                end
            end

            ST_LSTART:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_item_next.kind           = prt_pkg::KIND_LIST_START;
                    out_item_next.entry_address  = '0;
                    out_item_next.entry_port     = '0;
                    out_item_next.entry_sequence = '0;
                    out_item_next.last           = 1'b0;
                    state_next                   = ST_LIST;
                end
            end

            ST_LIST:
            begin
                consume      = p_valid_reg && out_free;
                can_issue    = !p_valid_reg || consume;
                p_valid_next = p_valid_reg && !consume;
                if (consume)
                begin
                    out_valid_next               = 1'b1;
                    out_item_next.kind           = prt_pkg::KIND_LIST_ENTRY;
                    out_item_next.entry_address  = mem_rd_data.address;
                    out_item_next.entry_port     = mem_rd_data.port;
                    out_item_next.entry_sequence = mem_rd_data.seq_num;
                    out_item_next.last           = 1'b0;
                end
                if (can_issue && !idx_done)
                begin
                    // Free slots are skipped without a read.
                    if (slot_valid_reg[idx_addr])
                    begin
                        mem_rd_en    = 1'b1;
                        p_valid_next = 1'b1;
                        p_idx_next   = idx_addr;
                    end
                    idx_next = idx_reg + IW'(1);
                end
                if (!p_valid_reg && idx_done)
                begin
                    res_kind_next = prt_pkg::KIND_LIST_END;
                    res_seq_next  = '0;
                    state_next    = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_item_next.kind           = res_kind_reg;
                    out_item_next.entry_address  = '0;
                    out_item_next.entry_port     = '0;
                    out_item_next.entry_sequence = res_seq_reg;
                    out_item_next.last           = 1'b1;
                    state_next                   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            p_valid_reg     <= 1'b0;
            slot_valid_reg  <= '0;
            next_number_reg <= 32'd1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            p_valid_reg     <= p_valid_next;
            slot_valid_reg  <= slot_valid_next;
            next_number_reg <= next_number_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= req.client_address;
            port_reg <= req.client_port;
            key_reg  <= req.sequence_key;
        end
        p_idx_reg    <= p_idx_next;
        res_kind_reg <= res_kind_next;
        res_seq_reg  <= res_seq_next;
        out_item_reg <= out_item_next;
    end

    // The sequence counter only ever moves forward by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (next_number_reg != $past(next_number_reg))
            |-> (next_number_reg == $past(next_number_reg) + 32'd1))
        else $error("sequence counter moved by other than one");

    // Single-result requests and the list end always close their item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && ((rsp.kind == prt_pkg::KIND_ASSIGNED)
            || (rsp.kind == prt_pkg::KIND_REMOVED)
            || (rsp.kind == prt_pkg::KIND_NOT_FOUND)
            || (rsp.kind == prt_pkg::KIND_LIST_END))) |-> rsp.last)
        else $error("closing result without last");

    // A pending slot read only exists during the unregister or list scans.
    assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> ((state_reg == ST_UNR) || (state_reg == ST_LIST)))
        else $error("slot read pending outside a scan");

    // The table contents change only while a request is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=> (slot_valid_reg == $past(slot_valid_reg)))
        else $error("slot valid bits changed while idle");

endmodule
